// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion wrappers. Expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, held off during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rpc_pkg.sv -----
// ---------------------------------------------------------------------------
// rpc_pkg
// Types, constants and gain helpers for the rate-probe congestion FSM.
// ---------------------------------------------------------------------------
package rpc_pkg;

    typedef enum logic [1:0] {
        MODE_STARTUP   = 2'd0,
        MODE_DRAIN     = 2'd1,
        MODE_PROBE_BW  = 2'd2,
        MODE_PROBE_RTT = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_STARTUP_GAIN     = 3'd0;
    localparam logic [2:0] CFG_STARTUP_GAIN_INV = 3'd1;
    localparam logic [2:0] CFG_GROWTH_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_STEADY_GAIN      = 3'd3;
    localparam logic [2:0] CFG_PROBE_INCREMENT  = 3'd4;
    localparam logic [2:0] CFG_DRAIN_DECREMENT  = 3'd5;
    localparam logic [2:0] CFG_MIN_CWND_BYTES   = 3'd6;
    localparam logic [2:0] CFG_PROBE_RTT_FLOOR  = 3'd7;

    // Reset values
    localparam logic [11:0] RST_STARTUP_GAIN     = 12'd740;
    localparam logic [11:0] RST_STARTUP_GAIN_INV = 12'd89;
    localparam logic [11:0] RST_GROWTH_THRESHOLD = 12'd320;
    localparam logic [11:0] RST_STEADY_GAIN      = 12'd256;
    localparam logic [11:0] RST_PROBE_INCREMENT  = 12'd64;
    localparam logic [11:0] RST_DRAIN_DECREMENT  = 12'd64;
    localparam logic [15:0] RST_MIN_CWND_BYTES   = 16'd6000;
    localparam logic [23:0] RST_PROBE_RTT_FLOOR  = 24'd200000;

    localparam logic [11:0] GAIN_MAX          = 12'hFFF;
    localparam logic [1:0]  STALL_LIMIT       = 2'd3;
    localparam logic [2:0]  DRAIN_ROUNDS_EXIT = 3'd5;
    localparam logic [2:0]  PHASE_UP          = 3'd0;
    localparam logic [2:0]  PHASE_DOWN        = 3'd1;

    function automatic logic [11:0] sat_add(logic [11:0] a, logic [11:0] b);
        logic [12:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, GAIN_MAX}) ? GAIN_MAX : s[11:0];
    endfunction

    function automatic logic [11:0] sat_sub(logic [11:0] a, logic [11:0] b);
        return (a > b) ? (a - b) : 12'd0;
    endfunction

endpackage

// ----- hw/rtl/rate_probe_congestion_fsm.sv -----
// ---------------------------------------------------------------------------
// rate_probe_congestion_fsm
// Per-round-tick mode controller: startup, drain, gain-cycling probe
// bandwidth and probe RTT, with Q4.8 pacing and window gains.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  item    | item_valid/item_stall| bw_estimate .. start_phase_code
//  result  | result_valid/stall   | mode, pacing_gain, cwnd_gain, force_min_cwnd,
//          |                      | cycle_phase
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  One tick per cycle sustained while the result is not stalled; an accepted
//  request goes through the input register and then into the result register.
//  The path that sets the rate is the 32x12 growth multiply and compare,
//  next to the 40-bit end-time add and compare, both into the state registers.
//  Reset puts the block in startup with the register reset values.
//  A stalled result holds; one more request waits in the input register.
`include "assert_macros.svh"

module rate_probe_congestion_fsm #(
    parameter bit PACING_ENABLED = 1'b1
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [31:0]          bw_estimate,
    input  logic                 bw_valid,
    input  logic [31:0]          bdp_bytes,
    input  logic [31:0]          inflight_bytes,
    input  logic [31:0]          min_rtt_us,
    input  logic [39:0]          now_us,
    input  logic                 probe_rtt_due,
    input  logic [2:0]           start_phase_code,

    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [1:0]           mode,
    output logic [11:0]          pacing_gain,
    output logic [11:0]          cwnd_gain,
    output logic                 force_min_cwnd,
    output logic [2:0]           cycle_phase,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [23:0]          cfg_data
);
    import rpc_pkg::*;

    // Configuration
    logic [11:0] startup_gain_reg, startup_gain_inv_reg, growth_threshold_reg;
    logic [11:0] steady_gain_reg, probe_increment_reg, drain_decrement_reg;
    logic [15:0] min_cwnd_bytes_reg;
    logic [23:0] probe_rtt_floor_reg;

    // Input register
    logic        held_reg;
    logic [31:0] bw_reg, bdp_reg, inflight_reg, min_rtt_reg;
    logic        bw_valid_reg, due_reg;
    logic [39:0] now_reg;
    logic [2:0]  code_reg;

    // State
    mode_t       mode_reg, mode_next;
    logic [11:0] pace_gain_reg, pace_gain_next;
    logic [11:0] win_gain_reg, win_gain_next;
    logic [31:0] full_bw_reg, full_bw_next;
    logic [1:0]  stall_rounds_reg, stall_rounds_next;
    logic [31:0] drain_target_reg, drain_target_next;
    logic [2:0]  drain_rounds_reg, drain_rounds_next;
    logic [2:0]  gain_phase_reg, gain_phase_next;
    logic [39:0] probe_rtt_end_reg, probe_rtt_end_next;
    logic        force_reg, force_next;
    logic        result_valid_reg;

    logic        advance;
    logic        accept;
    logic [31:0] dwell;
    logic [39:0] rtt_end_new;
    logic [43:0] growth_product;
    logic        grows;
    logic [2:0]  entry_phase;
    logic [11:0] entry_pace, entry_win;
    logic [11:0] cycle_pace;
    logic [11:0] steady_doubled;
    logic [1:0]  stall_inc;
    logic [2:0]  drain_inc;
    mode_t       mode_act;

    assign advance    = held_reg && (!result_valid_reg || !result_stall);
    assign item_stall = held_reg && !advance;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            startup_gain_reg     <= RST_STARTUP_GAIN;
            startup_gain_inv_reg <= RST_STARTUP_GAIN_INV;
            growth_threshold_reg <= RST_GROWTH_THRESHOLD;
            steady_gain_reg      <= RST_STEADY_GAIN;
            probe_increment_reg  <= RST_PROBE_INCREMENT;
            drain_decrement_reg  <= RST_DRAIN_DECREMENT;
            min_cwnd_bytes_reg   <= RST_MIN_CWND_BYTES;
            probe_rtt_floor_reg  <= RST_PROBE_RTT_FLOOR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STARTUP_GAIN:     startup_gain_reg     <= cfg_data[11:0];
                CFG_STARTUP_GAIN_INV: startup_gain_inv_reg <= cfg_data[11:0];
                CFG_GROWTH_THRESHOLD: growth_threshold_reg <= cfg_data[11:0];
                CFG_STEADY_GAIN:      steady_gain_reg      <= cfg_data[11:0];
                CFG_PROBE_INCREMENT:  probe_increment_reg  <= cfg_data[11:0];
                CFG_DRAIN_DECREMENT:  drain_decrement_reg  <= cfg_data[11:0];
                CFG_MIN_CWND_BYTES:   min_cwnd_bytes_reg   <= cfg_data[15:0];
                CFG_PROBE_RTT_FLOOR:  probe_rtt_floor_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg <= 1'b1;
        end
        else if (advance)
        begin
            held_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bw_reg       <= bw_estimate;
            bw_valid_reg <= bw_valid;
            bdp_reg      <= bdp_bytes;
            inflight_reg <= inflight_bytes;
            min_rtt_reg  <= min_rtt_us;
            now_reg      <= now_us;
            due_reg      <= probe_rtt_due;
            code_reg     <= start_phase_code;
        end
    end

    // Tick datapath
    assign dwell          = (min_rtt_reg > {8'd0, probe_rtt_floor_reg}) ?
                            min_rtt_reg : {8'd0, probe_rtt_floor_reg};
    assign rtt_end_new    = now_reg + {8'd0, dwell};
    assign growth_product = full_bw_reg * growth_threshold_reg;
    assign grows          = {4'd0, bw_reg, 8'd0} > growth_product;
    assign stall_inc      = (stall_rounds_reg < STALL_LIMIT) ?
                            stall_rounds_reg + 2'd1 : stall_rounds_reg;
    assign drain_inc      = drain_rounds_reg + 3'd1;
    assign steady_doubled = sat_add(steady_gain_reg, steady_gain_reg);

    // code 0 -> phase 0, code k -> k+1 (seven wraps to zero)
    assign entry_phase = (code_reg == 3'd0) ? 3'd0 : code_reg + 3'd1;
    assign entry_pace  = (entry_phase == PHASE_UP) ?
                         sat_add(steady_gain_reg, probe_increment_reg) : steady_gain_reg;
    assign entry_win   = PACING_ENABLED ? steady_doubled : entry_pace;

    always_comb
    begin
        case (gain_phase_reg)
            PHASE_UP:   cycle_pace = sat_add(steady_gain_reg, probe_increment_reg);
            PHASE_DOWN: cycle_pace = PACING_ENABLED ?
                                     sat_sub(steady_gain_reg, drain_decrement_reg) :
                                     sat_sub(steady_gain_reg, drain_decrement_reg >> 3);
            default:    cycle_pace = steady_gain_reg;
        endcase
    end

    always_comb
    begin
        mode_next          = mode_reg;
        pace_gain_next     = pace_gain_reg;
        win_gain_next      = win_gain_reg;
        full_bw_next       = full_bw_reg;
        stall_rounds_next  = stall_rounds_reg;
        drain_target_next  = drain_target_reg;
        drain_rounds_next  = drain_rounds_reg;
        gain_phase_next    = gain_phase_reg;
        probe_rtt_end_next = probe_rtt_end_reg;
        force_next         = 1'b0;

        // due request takes effect before the mode action
        if (due_reg)
        begin
            mode_next          = MODE_PROBE_RTT;
            pace_gain_next     = steady_gain_reg;
            win_gain_next      = steady_gain_reg;
            probe_rtt_end_next = rtt_end_new;
        end
        mode_act = mode_next;

        unique case (mode_act)
            MODE_STARTUP:
            begin
                if (bw_valid_reg)
                begin
                    if (grows)
                    begin
                        full_bw_next      = bw_reg;
                        stall_rounds_next = 2'd0;
                    end
                    else
                    begin
                        stall_rounds_next = stall_inc;
                        if (stall_inc == STALL_LIMIT)
                        begin
                            mode_next         = MODE_DRAIN;
                            pace_gain_next    = startup_gain_inv_reg;
                            win_gain_next     = PACING_ENABLED ?
                                                startup_gain_reg : startup_gain_inv_reg;
                            drain_target_next = bdp_reg;
                            drain_rounds_next = 3'd0;
                        end
                    end
                end
            end
            MODE_DRAIN:
            begin
                drain_rounds_next = drain_inc;
                if (inflight_reg < drain_target_reg || drain_inc == DRAIN_ROUNDS_EXIT)
                begin
                    mode_next       = MODE_PROBE_BW;
                    gain_phase_next = entry_phase;
                    pace_gain_next  = entry_pace;
                    win_gain_next   = entry_win;
                end
            end
            MODE_PROBE_BW:
            begin
                pace_gain_next  = cycle_pace;
                win_gain_next   = PACING_ENABLED ? steady_doubled : cycle_pace;
                gain_phase_next = gain_phase_reg + 3'd1;
            end
            MODE_PROBE_RTT:
            begin
                force_next = 1'b1;
                // end time is the one just set if due was raised on this tick, else the stored one
                if (now_reg > probe_rtt_end_next)
                begin
                    mode_next       = MODE_PROBE_BW;
                    gain_phase_next = entry_phase;
                    pace_gain_next  = entry_pace;
                    win_gain_next   = entry_win;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_STARTUP;
            pace_gain_reg     <= RST_STARTUP_GAIN;
            win_gain_reg      <= RST_STARTUP_GAIN;
            full_bw_reg       <= 32'd0;
            stall_rounds_reg  <= 2'd0;
            drain_target_reg  <= 32'd0;
            drain_rounds_reg  <= 3'd0;
            gain_phase_reg    <= 3'd0;
            probe_rtt_end_reg <= 40'd0;
            force_reg         <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg          <= mode_next;
            pace_gain_reg     <= pace_gain_next;
            win_gain_reg      <= win_gain_next;
            full_bw_reg       <= full_bw_next;
            stall_rounds_reg  <= stall_rounds_next;
            drain_target_reg  <= drain_target_next;
            drain_rounds_reg  <= drain_rounds_next;
            gain_phase_reg    <= gain_phase_next;
            probe_rtt_end_reg <= probe_rtt_end_next;
            force_reg         <= force_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // State only moves on advance, so it doubles as the result register.
    assign result_valid   = result_valid_reg;
    assign mode           = mode_reg;
    assign pacing_gain    = pace_gain_reg;
    assign cwnd_gain      = win_gain_reg;
    assign force_min_cwnd = force_reg;
    assign cycle_phase    = gain_phase_reg;

    // min_cwnd_bytes is only held and drives no output; the user applies it when the force flag is set.
    logic min_cwnd_nonzero;
    assign min_cwnd_nonzero = |min_cwnd_bytes_reg;

    `ASSERT_IMPLIES(a_rtt_forces, result_valid && mode == MODE_PROBE_RTT,
        force_min_cwnd, "probe RTT result without window force")
    `ASSERT_IMPLIES(a_force_mode, result_valid && force_min_cwnd,
        mode == MODE_PROBE_RTT || mode == MODE_PROBE_BW, "force flag in wrong mode")
    `ASSERT_NEXT(a_state_hold, !advance, $stable(mode_reg) && $stable(gain_phase_reg),
        "state moved without a tick")
    `ASSERT_IMPLIES(a_backpressure, held_reg && result_valid && result_stall,
        item_stall, "input register overrun while result stalled")
    `ASSERT_IMPLIES(a_cfg_floor_seen, cfg_valid && cfg_index == CFG_MIN_CWND_BYTES,
        cfg_ready || !min_cwnd_nonzero, "config write refused")

endmodule

// ----- tb/rpc_mode_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rpc_mode_checker
// Watches the request, result and register channels of the rate-probe
// congestion FSM. Every accepted request is run through an untimed copy of
// the mode machine. Every accepted result is compared, field by field and in
// order, with the oldest prediction.
// ---------------------------------------------------------------------------
module rpc_mode_checker #(
    parameter bit PACING_ENABLED = 1'b1
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [31:0] bw_estimate,
    input  logic        bw_valid,
    input  logic [31:0] bdp_bytes,
    input  logic [31:0] inflight_bytes,
    input  logic [31:0] min_rtt_us,
    input  logic [39:0] now_us,
    input  logic        probe_rtt_due,
    input  logic [2:0]  start_phase_code,

    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [1:0]  mode,
    input  logic [11:0] pacing_gain,
    input  logic [11:0] cwnd_gain,
    input  logic        force_min_cwnd,
    input  logic [2:0]  cycle_phase,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,

    output int          mismatches,
    output int          outstanding
);
    import rpc_pkg::*;

    typedef struct {
        logic [31:0] bw;
        logic        bw_ok;
        logic [31:0] bdp;
        logic [31:0] inflight;
        logic [31:0] rtt;
        logic [39:0] stamp;
        logic        due;
        logic [2:0]  code;
    } tick_t;

    typedef struct {
        mode_t       mode;
        logic [11:0] pace;
        logic [11:0] win;
        logic        min_win;
        logic [2:0]  phase;
    } gains_t;

    // register copy
    logic [11:0] k_startup, k_startup_inv, k_growth, k_steady, k_probe_inc, k_drain_dec;
    logic [15:0] k_min_cwnd;
    logic [23:0] k_rtt_floor;

    // mode machine copy
    mode_t       s_mode;
    logic [11:0] s_pace, s_win;
    logic [31:0] s_full_bw;
    logic [1:0]  s_stalls;
    logic [31:0] s_drain_target;
    logic [2:0]  s_drain_rounds;
    logic [2:0]  s_phase;
    logic [39:0] s_rtt_end;

    gains_t expected_gains[$];
    int     results_seen = 0;

    initial mismatches = 0;
    initial outstanding = 0;

    function automatic logic [11:0] gain_plus(logic [11:0] a, logic [11:0] b);
        int unsigned total;
        total = a + b;
        return (total > GAIN_MAX) ? GAIN_MAX : total[11:0];
    endfunction

    function automatic logic [11:0] gain_minus(logic [11:0] a, logic [11:0] b);
        int diff;
        diff = int'(a) - int'(b);
        return (diff < 0) ? 12'd0 : diff[11:0];
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatches < 200)
            $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic enter_drain(input logic [31:0] bdp);
        s_mode         = MODE_DRAIN;
        s_pace         = k_startup_inv;
        s_win          = PACING_ENABLED ? k_startup : k_startup_inv;
        s_drain_target = bdp;
        s_drain_rounds = '0;
    endtask

    task automatic enter_probe_bw(input logic [2:0] code);
        s_mode  = MODE_PROBE_BW;
        // code 0 starts at phase zero, nonzero code k at phase k+1, so seven lands on phase zero
        s_phase = (code == 3'd0) ? 3'd0 : code + 3'd1;
        s_pace  = (s_phase == PHASE_UP) ? gain_plus(k_steady, k_probe_inc) : k_steady;
        s_win   = PACING_ENABLED ? gain_plus(k_steady, k_steady) : s_pace;
    endtask

    task automatic enter_probe_rtt(input logic [31:0] rtt, input logic [39:0] stamp);
        logic [39:0] dwell;
        dwell     = (rtt > {8'd0, k_rtt_floor}) ? {8'd0, rtt} : {16'd0, k_rtt_floor};
        s_mode    = MODE_PROBE_RTT;
        s_pace    = k_steady;
        s_win     = k_steady;
        s_rtt_end = stamp + dwell;   // wraps at 40 bits
    endtask

    task automatic step_mode_fsm(input tick_t t, output gains_t r);
        longint unsigned offered, needed;
        r.min_win = 1'b0;
        if (t.due)
            enter_probe_rtt(t.rtt, t.stamp);
        case (s_mode)
            MODE_STARTUP:
            begin
                if (t.bw_ok)
                begin
                    offered = t.bw;
                    offered = offered << 8;
                    needed  = s_full_bw;
                    needed  = needed * k_growth;
                    if (offered > needed)
                    begin
                        s_full_bw = t.bw;
                        s_stalls  = '0;
                    end
                    else
                    begin
                        if (s_stalls < STALL_LIMIT)
                            s_stalls = s_stalls + 2'd1;
                        if (s_stalls == STALL_LIMIT)
                            enter_drain(t.bdp);
                    end
                end
            end
            MODE_DRAIN:
            begin
                s_drain_rounds = s_drain_rounds + 3'd1;
                if (t.inflight < s_drain_target || s_drain_rounds == DRAIN_ROUNDS_EXIT)
                    enter_probe_bw(t.code);
            end
            MODE_PROBE_BW:
            begin
                if (s_phase == PHASE_UP)
                    s_pace = gain_plus(k_steady, k_probe_inc);
                else if (s_phase == PHASE_DOWN)
                    s_pace = PACING_ENABLED ? gain_minus(k_steady, k_drain_dec)
                                            : gain_minus(k_steady, k_drain_dec >> 3);
                else
                    s_pace = k_steady;
                s_win   = PACING_ENABLED ? gain_plus(k_steady, k_steady) : s_pace;
                s_phase = s_phase + 3'd1;
            end
            default:
            begin
                r.min_win = 1'b1;
                if (t.stamp > s_rtt_end)
                    enter_probe_bw(t.code);
            end
        endcase
        r.mode  = s_mode;
        r.pace  = s_pace;
        r.win   = s_win;
        r.phase = s_phase;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_t  req;
        gains_t want, fresh;
        if (!rst_n)
        begin
            k_startup      = RST_STARTUP_GAIN;
            k_startup_inv  = RST_STARTUP_GAIN_INV;
            k_growth       = RST_GROWTH_THRESHOLD;
            k_steady       = RST_STEADY_GAIN;
            k_probe_inc    = RST_PROBE_INCREMENT;
            k_drain_dec    = RST_DRAIN_DECREMENT;
            k_min_cwnd     = RST_MIN_CWND_BYTES;
            k_rtt_floor    = RST_PROBE_RTT_FLOOR;
            s_mode         = MODE_STARTUP;
            s_pace         = RST_STARTUP_GAIN;
            s_win          = RST_STARTUP_GAIN;
            s_full_bw      = '0;
            s_stalls       = '0;
            s_drain_target = '0;
            s_drain_rounds = '0;
            s_phase        = '0;
            s_rtt_end      = '0;
            expected_gains.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STARTUP_GAIN:     k_startup     = cfg_data[11:0];
                    CFG_STARTUP_GAIN_INV: k_startup_inv = cfg_data[11:0];
                    CFG_GROWTH_THRESHOLD: k_growth      = cfg_data[11:0];
                    CFG_STEADY_GAIN:      k_steady      = cfg_data[11:0];
                    CFG_PROBE_INCREMENT:  k_probe_inc   = cfg_data[11:0];
                    CFG_DRAIN_DECREMENT:  k_drain_dec   = cfg_data[11:0];
                    CFG_MIN_CWND_BYTES:   k_min_cwnd    = cfg_data[15:0];
                    CFG_PROBE_RTT_FLOOR:  k_rtt_floor   = cfg_data;
                    default: ;
                endcase
            end

            // retire before predicting, so a stray result is never matched
            // against a request accepted on the same edge
            if (result_valid && !result_stall)
            begin
                if (expected_gains.size() == 0)
                    note_mismatch($sformatf("result %0d arrived with nothing pending",
                                            results_seen));
                else
                begin
                    want = expected_gains.pop_front();
                    if (mode !== want.mode)
                        note_mismatch($sformatf("result %0d: mode %0d, expected %s",
                                                results_seen, mode, want.mode.name()));
                    if (pacing_gain !== want.pace)
                        note_mismatch($sformatf("result %0d: pacing_gain %0d, expected %0d",
                                                results_seen, pacing_gain, want.pace));
                    if (cwnd_gain !== want.win)
                        note_mismatch($sformatf("result %0d: cwnd_gain %0d, expected %0d",
                                                results_seen, cwnd_gain, want.win));
                    if (force_min_cwnd !== want.min_win)
                        note_mismatch($sformatf("result %0d: force_min_cwnd %b, expected %b",
                                                results_seen, force_min_cwnd, want.min_win));
                    if (cycle_phase !== want.phase)
                        note_mismatch($sformatf("result %0d: cycle_phase %0d, expected %0d",
                                                results_seen, cycle_phase, want.phase));
                end
                results_seen++;
            end

            if (item_valid && !item_stall)
            begin
                req = '{bw_estimate, bw_valid, bdp_bytes, inflight_bytes, min_rtt_us,
                        now_us, probe_rtt_due, start_phase_code};
                step_mode_fsm(req, fresh);
                expected_gains.push_back(fresh);
            end

            outstanding <= expected_gains.size();
        end
    end

endmodule

// ----- tb/rate_probe_congestion_fsm_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rate_probe_congestion_fsm_tb
// Drives round ticks into the congestion FSM: a directed walk through
// startup, drain, the gain cycle and probe RTT, then three random phases
// under different register settings and handshake idling. The checker
// beside the block predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module rate_probe_congestion_fsm_tb;
    import rpc_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 300;
    localparam int TICKS_PER_PHASE = 560;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;

    logic        item_valid       = 1'b0;
    logic        item_stall;
    logic [31:0] bw_estimate      = '0;
    logic        bw_valid         = 1'b0;
    logic [31:0] bdp_bytes        = '0;
    logic [31:0] inflight_bytes   = '0;
    logic [31:0] min_rtt_us       = '0;
    logic [39:0] now_us           = '0;
    logic        probe_rtt_due    = 1'b0;
    logic [2:0]  start_phase_code = '0;

    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  mode;
    logic [11:0] pacing_gain;
    logic [11:0] cwnd_gain;
    logic        force_min_cwnd;
    logic [2:0]  cycle_phase;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    int          mismatches;
    int          outstanding;

    int          src_idle    = 31;
    int          rcv_idle    = 83;
    logic        hold_off    = 1'b0;
    bit          pressure_go = 1'b0;
    int          cycle_count = 0;
    logic [39:0] clock_us    = '0;
    int unsigned step_max    = 100000;

    rate_probe_congestion_fsm #(.PACING_ENABLED(1'b1)) DUT (.*);

    rpc_mode_checker #(.PACING_ENABLED(1'b1)) mode_check (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        result_stall <= hold_off || ($urandom_range(99) < rcv_idle);

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic offer_tick(input logic [31:0] bw, input logic bw_ok,
                              input logic [31:0] bdp, input logic [31:0] inflight,
                              input logic [31:0] rtt, input logic [39:0] stamp,
                              input logic due, input logic [2:0] code);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle)
            gap++;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid       <= 1'b1;
        bw_estimate      <= bw;
        bw_valid         <= bw_ok;
        bdp_bytes        <= bdp;
        inflight_bytes   <= inflight;
        min_rtt_us       <= rtt;
        now_us           <= stamp;
        probe_rtt_due    <= due;
        start_phase_code <= code;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // mostly a steadily advancing clock; now and then a jump anywhere or
    // close to the 40-bit wrap
    task automatic random_tick();
        int unsigned pick;
        logic [31:0] rtt;
        pick = $urandom_range(99);
        if (pick < 3)
            clock_us = {8'($urandom), 32'($urandom)};
        else if (pick < 5)
            clock_us = 40'hFF_FFFF_FFFF - 40'($urandom_range(4000000));
        else
            clock_us = clock_us + 40'($urandom_range(step_max));
        pick = $urandom_range(99);
        if (pick < 10)
            rtt = '0;
        else if (pick < 97)
            rtt = $urandom_range(300000);
        else
            rtt = $urandom;
        offer_tick($urandom, 1'($urandom), $urandom, $urandom, rtt, clock_us,
                   $urandom_range(99) < 8, 3'($urandom));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [11:0] sg, input logic [11:0] sg_inv,
                                input logic [11:0] grow, input logic [11:0] steady,
                                input logic [11:0] inc, input logic [11:0] dec,
                                input logic [15:0] min_cw, input logic [23:0] floor_us);
        write_reg(CFG_STARTUP_GAIN,     {12'd0, sg});
        write_reg(CFG_STARTUP_GAIN_INV, {12'd0, sg_inv});
        write_reg(CFG_GROWTH_THRESHOLD, {12'd0, grow});
        write_reg(CFG_STEADY_GAIN,      {12'd0, steady});
        write_reg(CFG_PROBE_INCREMENT,  {12'd0, inc});
        write_reg(CFG_DRAIN_DECREMENT,  {12'd0, dec});
        write_reg(CFG_MIN_CWND_BYTES,   {8'd0, min_cw});
        write_reg(CFG_PROBE_RTT_FLOOR,  floor_us);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // startup gains rewritten before any tick: live gains stay at the
        // reset value until drain entry picks up the new ones
        program_regs(12'd4095, 12'd0, RST_GROWTH_THRESHOLD, RST_STEADY_GAIN,
                     RST_PROBE_INCREMENT, RST_DRAIN_DECREMENT, RST_MIN_CWND_BYTES,
                     RST_PROBE_RTT_FLOOR);

        // startup: no estimate, zero estimate, growth, then three flat rounds
        offer_tick(32'hFFFF_FFFF, 1'b0, '0, '0, '0, 40'd10, 1'b0, 3'd0);
        offer_tick(32'd0,         1'b1, '0, '0, '0, 40'd20, 1'b0, 3'd0);
        offer_tick(32'd1,         1'b1, '0, '0, '0, 40'd30, 1'b0, 3'd0);
        offer_tick(32'hFFFF_FFFF, 1'b1, '0, '0, '0, 40'd40, 1'b0, 3'd0);
        offer_tick(32'hFFFF_FFFF, 1'b1, '0, '0, '0, 40'd50, 1'b0, 3'd0);
        offer_tick(32'hFFFF_FFFF, 1'b1, '0, '0, '0, 40'd60, 1'b0, 3'd0);
        offer_tick(32'hFFFF_FFFF, 1'b1, 32'h8000_0000, '0, '0, 40'd70, 1'b0, 3'd0);
        // drain: inflight equal to target never exits, so rounds run out
        offer_tick('0, 1'b0, '0, 32'h8000_0000, '0, 40'd80, 1'b0, 3'd3);
        offer_tick('0, 1'b0, '0, 32'h8000_0000, '0, 40'd90, 1'b0, 3'd3);
        offer_tick('0, 1'b0, '0, 32'h8000_0000, '0, 40'd100, 1'b0, 3'd3);
        offer_tick('0, 1'b0, '0, 32'h8000_0000, '0, 40'd110, 1'b0, 3'd3);
        // start code seven wraps to phase zero
        offer_tick('0, 1'b0, '0, 32'hFFFF_FFFF, '0, 40'd120, 1'b0, 3'd7);
        for (n = 0; n < 8; n++)
            offer_tick(32'h5555_5555, 1'b1, 32'hAAAA_AAAA, '0, '0, 40'd200 + 40'(n),
                       1'b0, 3'(n));
        // probe RTT on the floor, re-entered while dwelling, then left
        offer_tick('0, 1'b0, '0, '0, 32'd0, 40'd1000, 1'b1, 3'd1);
        offer_tick('0, 1'b0, '0, '0, 32'hFFFF_FFFF, 40'd2000, 1'b1, 3'd2);
        offer_tick('0, 1'b0, '0, '0, '0, 40'd4294969296, 1'b0, 3'd6);
        // end time wraps past 2^40 and is already behind now
        offer_tick('0, 1'b0, '0, '0, 32'd300000, 40'hFF_FFFF_FFFF, 1'b1, 3'd0);
        offer_tick('0, 1'b0, '0, '0, '0, '0, 1'b0, 3'd0);

        // largest gains: every sum saturates
        settle();
        program_regs(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                     16'hFFFF, 24'hFF_FFFF);
        step_max = 4000000;
        repeat (TICKS_PER_PHASE) random_tick();

        // everything zero; dwell comes from min RTT alone
        settle();
        program_regs('0, '0, '0, '0, '0, '0, '0, '0);
        src_idle = 83;
        rcv_idle <= 31;
        step_max = 100000;
        repeat (TICKS_PER_PHASE) random_tick();

        // probe sum overflows, drain difference underflows
        settle();
        program_regs(12'd512, 12'd128, 12'd384, 12'd200, 12'd4000, 12'd300,
                     16'd1500, 24'd50000);
        src_idle = 0;
        rcv_idle <= 0;
        step_max = 30000;
        for (n = 0; n < TICKS_PER_PHASE; n++)
        begin
            if (n == 40)
                pressure_go = 1'b1;
            random_tick();
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
